@@ rtl/lztd_pkg.sv @@
// Shared constants and the command type of the LZ77 triple decoder.
package lztd_pkg;

    localparam int PACK_W            = 8;
    localparam int DIST_W            = 12;
    localparam int LEN_W             = 4;
    localparam int CHAR_W            = 16;
    localparam int HISTORY_DEPTH_DEF = 4096;
    localparam int CHAR_BITS_DEF     = 16;
    localparam int CMD_FIFO_DEPTH    = 2;

    localparam logic [DIST_W-1:0] DIST_HI_MASK = 12'hFF0;
    localparam logic [PACK_W-1:0] NIBBLE_MASK  = 8'h0F;

    // One classified triple; len is the raw copy length, bad marks a rejected copy
    typedef struct packed {
        logic [DIST_W-1:0] back_dist;
        logic [LEN_W-1:0]  len;
        logic              has_lit;
        logic              bad;
    } cmd_t;

endpackage

@@ rtl/lztd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module lztd_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 4096
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read-first on a clash; the caller forwards where that matters
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

@@ rtl/lztd_front.sv @@
// Front end: accepts triples, checks references against the produced count, queues commands.
module lztd_front #(
    parameter int HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        triple_valid,
    output logic                        triple_ready,
    input  logic [lztd_pkg::PACK_W-1:0] packed_high,
    input  logic [lztd_pkg::PACK_W-1:0] packed_low,
    input  logic [lztd_pkg::CHAR_W-1:0] literal_char,
    input  logic                        literal_present,
    input  logic                        new_stream,
    output lztd_pkg::cmd_t              cmd,
    output logic [lztd_pkg::CHAR_W-1:0] cmd_lit,
    output logic                        cmd_valid,
    input  logic                        cmd_pop
);

    import lztd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int PW = AW + 1;
    localparam int MW = (PW > DIST_W) ? PW : DIST_W;
    localparam int QW = $clog2(CMD_FIFO_DEPTH);
    localparam int FW = $clog2(CMD_FIFO_DEPTH + 1);

    logic [PW-1:0]     count_reg, count_next;
    logic [PW-1:0]     count_base;
    logic [PW:0]       count_sum;
    logic [LEN_W:0]    written;
    logic [DIST_W-1:0] back_dist;
    logic [LEN_W-1:0]  len;
    logic              bad;
    logic              accept;
    logic              push;
    logic              pop;
    cmd_t              new_cmd;

    cmd_t              q_cmd [CMD_FIFO_DEPTH];
    logic [CHAR_W-1:0] q_lit [CMD_FIFO_DEPTH];
    logic [QW-1:0]     head_reg, head_next;
    logic [QW-1:0]     tail_reg, tail_next;
    logic [FW-1:0]     fill_reg, fill_next;

    // Field unpacking
    always_comb
    begin
        back_dist = ((DIST_W'(packed_high) << 4) & DIST_HI_MASK)
                  | DIST_W'((packed_low >> 4) & NIBBLE_MASK);
        len       = LEN_W'(packed_low & NIBBLE_MASK);
    end

    // Reference check and produced-count update, saturating at the history depth
    always_comb
    begin
        count_base = new_stream ? '0 : count_reg;
        bad        = (len != '0)
                   && ((back_dist == '0) || (MW'(back_dist) > MW'(count_base)));
        written    = (bad ? '0 : {1'b0, len}) + {{LEN_W{1'b0}}, literal_present};
        count_sum  = {1'b0, count_base} + (PW+1)'(written);
        if (count_sum > (PW+1)'(HISTORY_DEPTH))
        begin
            count_sum = (PW+1)'(HISTORY_DEPTH);
        end
        count_next = accept ? PW'(count_sum) : count_reg;
    end

    assign new_cmd.back_dist = back_dist;
    assign new_cmd.len       = len;
    assign new_cmd.has_lit   = literal_present;
    assign new_cmd.bad       = bad;

    // Command queue
    assign triple_ready = (fill_reg != FW'(CMD_FIFO_DEPTH));
    assign cmd_valid    = (fill_reg != '0);
    assign accept       = triple_valid && triple_ready;
    assign push         = accept && ((len != '0) || literal_present);
    assign pop          = cmd_pop && cmd_valid;
    assign cmd          = q_cmd[head_reg];
    assign cmd_lit      = q_lit[head_reg];

    always_comb
    begin
        head_next = head_reg;
        tail_next = tail_reg;
        fill_next = fill_reg;
        if (push)
        begin
            tail_next = (tail_reg == QW'(CMD_FIFO_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
        end
        if (pop)
        begin
            head_next = (head_reg == QW'(CMD_FIFO_DEPTH - 1)) ? '0 : head_reg + 1'b1;
        end
        if (push && !pop)
        begin
            fill_next = fill_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            fill_next = fill_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            head_reg  <= '0;
            tail_reg  <= '0;
            fill_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            fill_reg  <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_cmd[tail_reg] <= new_cmd;
            q_lit[tail_reg] <= literal_char;
        end
    end

endmodule

@@ rtl/lztd_back.sv @@
// Back end: runs each command against the history and drives the output register.
module lztd_back #(
    parameter int HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF,
    parameter int CHAR_BITS     = lztd_pkg::CHAR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  lztd_pkg::cmd_t              cmd,
    input  logic [lztd_pkg::CHAR_W-1:0] cmd_lit,
    input  logic                        cmd_valid,
    output logic                        cmd_pop,
    output logic                        char_valid,
    input  logic                        char_ready,
    output logic [lztd_pkg::CHAR_W-1:0] out_char,
    output logic                        bad_reference,
    output logic                        last_of_item
);

    import lztd_pkg::*;

    localparam int AW = $clog2(HISTORY_DEPTH);
    localparam int SW = ((AW > DIST_W) ? AW : DIST_W) + 1;
    localparam int CW = (CHAR_BITS < CHAR_W) ? CHAR_BITS : CHAR_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_COPY = 2'd2;
    localparam logic [1:0] ST_LIT  = 2'd3;

    logic [1:0]       state_reg, state_next;
    cmd_t             cmd_reg, cmd_next;
    logic [CW-1:0]    lit_reg, lit_next;
    logic [LEN_W-1:0] cnt_reg, cnt_next;
    logic [AW-1:0]    wp_reg, wp_next;
    logic [AW-1:0]    rp_reg, rp_next;
    logic             fwd_reg, fwd_next;
    logic [CW-1:0]    last_char_reg, last_char_next;
    logic             out_valid_reg, out_valid_next;
    logic [CW-1:0]    out_char_reg, out_char_next;
    logic             out_bad_reg, out_bad_next;
    logic             out_last_reg, out_last_next;

    logic [SW-1:0]    diff;
    logic [AW-1:0]    rd_start;
    logic [AW-1:0]    wp_inc;
    logic [AW-1:0]    rp_inc;
    logic             out_free;
    logic [CW-1:0]    copy_data;

    logic             hist_wr_en;
    logic [CW-1:0]    hist_wr_data;
    logic             hist_rd_en;
    logic [AW-1:0]    hist_rd_addr;
    logic [CW-1:0]    hist_rd_data;

    lztd_ram #(
        .WIDTH (CW),
        .DEPTH (HISTORY_DEPTH)
    ) u_history (
        .clk     (clk),
        .wr_en   (hist_wr_en),
        .wr_addr (wp_reg),
        .wr_data (hist_wr_data),
        .rd_en   (hist_rd_en),
        .rd_addr (hist_rd_addr),
        .rd_data (hist_rd_data)
    );

    // Start of copy: write pointer minus distance, modulo depth
    always_comb
    begin
        diff = SW'(wp_reg) - SW'(cmd_reg.back_dist);
        if (diff[SW-1])
        begin
            diff = diff + SW'(HISTORY_DEPTH);
        end
        rd_start = AW'(diff);
    end

    assign wp_inc    = (wp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : wp_reg + 1'b1;
    assign rp_inc    = (rp_reg == AW'(HISTORY_DEPTH - 1)) ? '0 : rp_reg + 1'b1;
    assign out_free  = !out_valid_reg || char_ready;
    // distance one reads the entry written in the same cycle: take it from the bypass
    assign copy_data = fwd_reg ? last_char_reg : hist_rd_data;

    always_comb
    begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        lit_next       = lit_reg;
        cnt_next       = cnt_reg;
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        fwd_next       = fwd_reg;
        last_char_next = last_char_reg;
        out_valid_next = out_valid_reg && !char_ready;
        out_char_next  = out_char_reg;
        out_bad_next   = out_bad_reg;
        out_last_next  = out_last_reg;
        cmd_pop        = 1'b0;
        hist_wr_en     = 1'b0;
        hist_wr_data   = copy_data;
        hist_rd_en     = 1'b0;
        hist_rd_addr   = rp_inc;

        case (state_reg)
            ST_IDLE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop    = 1'b1;
                    cmd_next   = cmd;
                    lit_next   = CW'(cmd_lit);
                    cnt_next   = cmd.len;
                    state_next = ((cmd.len != '0) && !cmd.bad) ? ST_READ : ST_LIT;
                end
            end

            ST_READ:
            begin
                hist_rd_en   = 1'b1;
                hist_rd_addr = rd_start;
                rp_next      = rd_start;
                fwd_next     = 1'b0;
                state_next   = ST_COPY;
            end

            ST_COPY:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_char_next  = copy_data;
                    out_bad_next   = 1'b0;
                    out_last_next  = (cnt_reg == LEN_W'(1)) && !cmd_reg.has_lit;
                    hist_wr_en     = 1'b1;
                    wp_next        = wp_inc;
                    last_char_next = copy_data;
                    cnt_next       = cnt_reg - 1'b1;
                    if (cnt_reg != LEN_W'(1))
                    begin
                        hist_rd_en = 1'b1;
                        rp_next    = rp_inc;
                        fwd_next   = (cmd_reg.back_dist == DIST_W'(1));
                    end
                    else
                    begin
                        state_next = cmd_reg.has_lit ? ST_LIT : ST_IDLE;
                    end
                end
            end

            ST_LIT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_last_next  = 1'b1;
                    out_bad_next   = cmd_reg.bad;
                    if (cmd_reg.has_lit)
                    begin
                        out_char_next = lit_reg;
                        hist_wr_en    = 1'b1;
                        hist_wr_data  = lit_reg;
                        wp_next       = wp_inc;
                    end
                    else
                    begin
                        // rejected copy with no literal: lone marker, not stored
                        out_char_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wp_reg        <= '0;
            fwd_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            wp_reg        <= wp_next;
            fwd_reg       <= fwd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg       <= cmd_next;
        lit_reg       <= lit_next;
        cnt_reg       <= cnt_next;
        rp_reg        <= rp_next;
        last_char_reg <= last_char_next;
        out_char_reg  <= out_char_next;
        out_bad_reg   <= out_bad_next;
        out_last_reg  <= out_last_next;
    end

    assign char_valid    = out_valid_reg;
    assign out_char      = CHAR_W'(out_char_reg);
    assign bad_reference = out_bad_reg;
    assign last_of_item  = out_last_reg;

endmodule

@@ rtl/lz77_triple_decoder_core.sv @@
// Top level of the LZ77 triple decoder: front end, command queue and back end.
//
// Input channel (triple_valid/triple_ready) takes one LZ77 triple per item:
// packed_high/packed_low carry a 12-bit back distance and a 4-bit length,
// literal_char/literal_present the trailing literal, new_stream restarts the
// produced-character count. Output channel (char_valid/char_ready) gives one
// decoded character per item, with bad_reference and last_of_item.
// The front end checks the reference at acceptance and pushes a command into a
// two-entry queue; input is refused only while that queue is full.
// The back end takes a copying triple through IDLE, READ and a COPY step per
// character, then LIT when a literal follows, and a literal-only or rejected
// one through IDLE and LIT: one history read per copied character, the single
// RAM read port setting the rate of one character a cycle while the output is
// not stalled; every character leaves through the output register.
// A stalled receiver holds the output register; the back end then waits with
// its read data held, and the queue keeps the front end taking items until full.
// Reset clears the queue and write pointers, count and control state only; history entries are
// not cleared and are only read once written, so no clearing pass is needed.
// A triple with zero length and no literal produces no output item.
module lz77_triple_decoder_core #(
    parameter int HISTORY_DEPTH = lztd_pkg::HISTORY_DEPTH_DEF,
    parameter int CHAR_BITS     = lztd_pkg::CHAR_BITS_DEF
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        triple_valid,
    output logic                        triple_ready,
    input  logic [lztd_pkg::PACK_W-1:0] packed_high,
    input  logic [lztd_pkg::PACK_W-1:0] packed_low,
    input  logic [lztd_pkg::CHAR_W-1:0] literal_char,
    input  logic                        literal_present,
    input  logic                        new_stream,
    output logic                        char_valid,
    input  logic                        char_ready,
    output logic [lztd_pkg::CHAR_W-1:0] out_char,
    output logic                        bad_reference,
    output logic                        last_of_item
);

    import lztd_pkg::*;

    // queue head as seen by the back end
    cmd_t              cmd;
    logic [CHAR_W-1:0] cmd_lit;
    logic              cmd_valid;
    logic              cmd_pop;

    lztd_front #(
        .HISTORY_DEPTH (HISTORY_DEPTH)
    ) u_front (
        .clk             (clk),
        .rst_n           (rst_n),
        .triple_valid    (triple_valid),
        .triple_ready    (triple_ready),
        .packed_high     (packed_high),
        .packed_low      (packed_low),
        .literal_char    (literal_char),
        .literal_present (literal_present),
        .new_stream      (new_stream),
        .cmd             (cmd),
        .cmd_lit         (cmd_lit),
        .cmd_valid       (cmd_valid),
        .cmd_pop         (cmd_pop)
    );

    lztd_back #(
        .HISTORY_DEPTH (HISTORY_DEPTH),
        .CHAR_BITS     (CHAR_BITS)
    ) u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .cmd_lit       (cmd_lit),
        .cmd_valid     (cmd_valid),
        .cmd_pop       (cmd_pop),
        .char_valid    (char_valid),
        .char_ready    (char_ready),
        .out_char      (out_char),
        .bad_reference (bad_reference),
        .last_of_item  (last_of_item)
    );

endmodule
